// ----- hw/rtl/sii_pkg.sv -----
// ----------------------------------------------------------------------------
// sii_pkg: shared types and constants of the sorted interval index
//
// Entry layout of the table memory, result kinds, add status codes,
// stream field widths and the state encoding of the sequencer.
// ----------------------------------------------------------------------------
package sii_pkg;

  localparam int VAL_W  = 64;
  localparam int KIND_W = 2;

  // Input tdata: entry_min, entry_max, entry_id, query_start, query_end
  localparam int IN_DATA_W  = 5 * VAL_W;
  // Output tdata: status, matching entry id, then zero fill to whole bytes
  localparam int OUT_USED_W = 1 + VAL_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // Input item kinds (tuser)
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result kinds (tuser)
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  // Add outcome
  localparam logic STATUS_STORED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  // One table entry as held in memory
  typedef struct packed {
    logic [VAL_W-1:0] seg_id;
    logic [VAL_W-1:0] rng_end;
    logic [VAL_W-1:0] rng_start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_PUT  = 5'b00100,
    ST_QRY  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/sii_ram.sv -----
// ----------------------------------------------------------------------------
// sii_ram: generic single-clock RAM
//
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/sorted_interval_index.sv -----
// ----------------------------------------------------------------------------
// sorted_interval_index: table of time ranges sorted by start, overlap query
//
// Input channel (in_*): one item per handshake. in_tuser selects the
// operation: add an entry (min, max, id) or query a range [start, end],
// where a zero start or end means no bound on that side.
// Result channel (out_*): an add gives one acknowledge item, status set
// when the table was full and the entry dropped. A query gives one match
// item per overlapping entry in table order, or one no-match item; tlast
// marks the final result item of each input item.
// All entries live in one memory of DEPTH words with a registered read port.
// An add walks down from the top entry, moving each larger-start entry up
// by one place per cycle, then writes the new entry into the freed place;
// an empty table takes the entry at the bottom and a full table drops it.
// A query reads one entry per cycle unless the receiver stalls a result
// item. A new item is taken in the cycle after the final result item of
// the previous one reaches the output register.
// Reset empties the table at once; no memory sweep is needed. When the
// receiver stalls a result item, the query walk holds and re-reads the
// current entry.
// ----------------------------------------------------------------------------
module sorted_interval_index
  import sii_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] entry_min, [127:64] entry_max, [191:128] entry_id,
  // [255:192] query_start, [319:256] query_end
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] status, [64:1] seg_id of the matching entry, [71:65] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [1:0] result_kind
  output logic [KIND_W-1:0]     out_tuser,
  output logic                  out_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     cnt_m1;
  logic [VAL_W-1:0]  op_a_r, op_a_nxt;
  logic [VAL_W-1:0]  op_b_r, op_b_nxt;
  logic [VAL_W-1:0]  op_c_r, op_c_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [VAL_W-1:0]  pend_id_r, pend_id_nxt;
  logic [KIND_W-1:0] fin_kind_r, fin_kind_nxt;
  logic              fin_status_r, fin_status_nxt;
  logic [VAL_W-1:0]  fin_id_r, fin_id_nxt;

  logic              out_vld_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_status_r;
  logic [VAL_W-1:0]  out_id_r;
  logic              out_last_r;

  logic              can_push;
  logic              push_vld;
  logic [KIND_W-1:0] push_kind;
  logic              push_status;
  logic [VAL_W-1:0]  push_id;
  logic              push_last;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  entry_t            new_entry;
  logic              hit;
  logic              adv;

  sii_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign can_push  = !out_vld_r || out_tready;
  assign cnt_m1    = cnt_r - CW'(1);

  assign new_entry.rng_start = op_a_r;
  assign new_entry.rng_end   = op_b_r;
  assign new_entry.seg_id    = op_c_r;

  // Overlap test of the entry on the read port against the held query
  assign hit = ((op_b_r == '0) || (rd_data.rng_start <= op_b_r)) &&
               ((op_a_r == '0) || (rd_data.rng_end >= op_a_r));

  // Sequencer: walk the table, move entries, collect results
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    op_a_nxt       = op_a_r;
    op_b_nxt       = op_b_r;
    op_c_nxt       = op_c_r;
    pend_vld_nxt   = pend_vld_r;
    pend_id_nxt    = pend_id_r;
    fin_kind_nxt   = fin_kind_r;
    fin_status_nxt = fin_status_r;
    fin_id_nxt     = fin_id_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data;
    rd_addr        = idx_r;
    push_vld       = 1'b0;
    push_kind      = KIND_MATCH;
    push_status    = STATUS_STORED;
    push_id        = pend_id_r;
    push_last      = 1'b0;
    adv            = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = (in_tuser == MODE_QUERY) ? '0 : cnt_m1[AW-1:0];
        if (in_tvalid) begin
          pend_vld_nxt   = 1'b0;
          fin_status_nxt = STATUS_STORED;
          fin_id_nxt     = '0;
          if (in_tuser == MODE_QUERY) begin
            op_a_nxt = in_tdata[4*VAL_W-1:3*VAL_W];
            op_b_nxt = in_tdata[5*VAL_W-1:4*VAL_W];
            if (cnt_r == '0) begin
              fin_kind_nxt = KIND_NONE;
              state_nxt    = ST_FIN;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_QRY;
            end
          end else begin
            op_a_nxt     = in_tdata[VAL_W-1:0];
            op_b_nxt     = in_tdata[2*VAL_W-1:VAL_W];
            op_c_nxt     = in_tdata[3*VAL_W-1:2*VAL_W];
            fin_kind_nxt = KIND_ACK;
            if (cnt_r >= CW'(DEPTH)) begin
              fin_status_nxt = STATUS_FULL;
              state_nxt      = ST_FIN;
            end else if (cnt_r == '0) begin
              // Empty table: store straight at the bottom
              wr_en                 = 1'b1;
              wr_addr               = '0;
              wr_data.rng_start     = in_tdata[VAL_W-1:0];
              wr_data.rng_end       = in_tdata[2*VAL_W-1:VAL_W];
              wr_data.seg_id        = in_tdata[3*VAL_W-1:2*VAL_W];
              cnt_nxt               = CW'(1);
              state_nxt             = ST_FIN;
            end else begin
              idx_nxt   = cnt_m1[AW-1:0];
              state_nxt = ST_ADD;
            end
          end
        end
      end

      ST_ADD: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (rd_data.rng_start > op_a_r) begin
          // Move this entry up and look one place lower
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = ST_PUT;
          end else begin
            idx_nxt = idx_r - AW'(1);
            rd_addr = idx_r - AW'(1);
          end
        end else begin
          wr_data   = new_entry;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_FIN;
        end
      end

      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_entry;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = ST_FIN;
      end

      ST_QRY: begin
        // Hold back one match so the final one can carry tlast
        adv = !(hit && pend_vld_r) || can_push;
        push_vld = hit && pend_vld_r && can_push;
        if (adv) begin
          if (hit) begin
            pend_vld_nxt = 1'b1;
            pend_id_nxt  = rd_data.seg_id;
          end
          if (idx_r == cnt_m1[AW-1:0]) begin
            fin_kind_nxt = (hit || pend_vld_r) ? KIND_MATCH : KIND_NONE;
            fin_id_nxt   = hit ? rd_data.seg_id : (pend_vld_r ? pend_id_r : '0);
            state_nxt    = ST_FIN;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_addr = idx_r + AW'(1);
          end
        end
      end

      ST_FIN: begin
        push_kind   = fin_kind_r;
        push_status = fin_status_r;
        push_id     = fin_id_r;
        push_last   = 1'b1;
        push_vld    = can_push;
        if (can_push) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (push_vld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold item operands and result payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_a_r       <= op_a_nxt;
    op_b_r       <= op_b_nxt;
    op_c_r       <= op_c_nxt;
    pend_id_r    <= pend_id_nxt;
    fin_kind_r   <= fin_kind_nxt;
    fin_status_r <= fin_status_nxt;
    fin_id_r     <= fin_id_nxt;
    if (push_vld) begin
      out_kind_r   <= push_kind;
      out_status_r <= push_status;
      out_id_r     <= push_id;
      out_last_r   <= push_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_id_r, out_status_r};

  // Entry count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // A no-match result is always final and carries no id
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == KIND_NONE)) |-> (out_last_r && (out_id_r == '0)))
    else $error("no-match result malformed");

  // Full status only on an add acknowledge
  a_full_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r) |-> (out_kind_r == KIND_ACK))
    else $error("full status on a query result");

  // Memory is written only while adding
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((state_r == ST_ADD) || (state_r == ST_PUT) ||
               ((state_r == ST_IDLE) && (in_tuser == MODE_ADD))))
    else $error("table write outside an add");

  // Count grows by one, only as an add completes
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |->
      ((state_r == ST_FIN) && (cnt_r == $past(cnt_r) + CW'(1))))
    else $error("entry count changed unexpectedly");

endmodule

// ----- tb/sorted_interval_index_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_interval_index_tb: self-checking bench for the sorted interval index
//
// Adds and overlap queries are driven in bursts with random gaps while the
// receiver stalls on a changing pattern, with one long hold-off that backs
// the block up. A scoreboard keeps its own sorted copy of the table, works
// out the result items of every accepted item and checks each result item
// in order.
// ----------------------------------------------------------------------------
module sorted_interval_index_tb
  import sii_pkg::*;
();

  localparam int TAB_DEPTH   = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 285;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [VAL_W-1:0]  seg;
    logic              is_last;
  } idx_result_t;

  // Scoreboard: sorted table copy and the queue of result items still due
  class interval_index_sb;
    logic [VAL_W-1:0] tab_lo [TAB_DEPTH];
    logic [VAL_W-1:0] tab_hi [TAB_DEPTH];
    logic [VAL_W-1:0] tab_id [TAB_DEPTH];
    int               fill;
    idx_result_t      due_results [$];
    int               errors;
    int               seen;

    function new();
      fill   = 0;
      errors = 0;
      seen   = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Work out the result items of one accepted item and queue them
    function void note_item(logic mode, logic [IN_DATA_W-1:0] data);
      logic [VAL_W-1:0] e_min, e_max, e_id, q_lo, q_hi;
      idx_result_t      r, held;
      int               pos;
      bit               have_held;
      e_min = data[VAL_W-1:0];
      e_max = data[2*VAL_W-1:VAL_W];
      e_id  = data[3*VAL_W-1:2*VAL_W];
      q_lo  = data[4*VAL_W-1:3*VAL_W];
      q_hi  = data[5*VAL_W-1:4*VAL_W];
      if (mode == MODE_ADD) begin
        r.kind    = KIND_ACK;
        r.status  = STATUS_FULL;
        r.seg     = '0;
        r.is_last = 1'b1;
        if (fill < TAB_DEPTH) begin
          // place after every entry with an equal or smaller start
          pos = 0;
          while (pos < fill && tab_lo[pos] <= e_min) pos++;
          for (int i = fill; i > pos; i--) begin
            tab_lo[i] = tab_lo[i-1];
            tab_hi[i] = tab_hi[i-1];
            tab_id[i] = tab_id[i-1];
          end
          tab_lo[pos] = e_min;
          tab_hi[pos] = e_max;
          tab_id[pos] = e_id;
          fill++;
          r.status = STATUS_STORED;
        end
        due_results.push_back(r);
      end else begin
        // hold back each match until the next is known, to mark the final one
        have_held = 1'b0;
        for (int i = 0; i < fill; i++) begin
          if ((q_hi == '0 || tab_lo[i] <= q_hi) && (q_lo == '0 || tab_hi[i] >= q_lo)) begin
            if (have_held) due_results.push_back(held);
            held.kind    = KIND_MATCH;
            held.status  = STATUS_STORED;
            held.seg     = tab_id[i];
            held.is_last = 1'b0;
            have_held    = 1'b1;
          end
        end
        if (have_held) begin
          held.is_last = 1'b1;
          due_results.push_back(held);
        end else begin
          r.kind    = KIND_NONE;
          r.status  = STATUS_STORED;
          r.seg     = '0;
          r.is_last = 1'b1;
          due_results.push_back(r);
        end
      end
    endfunction

    // Compare one accepted result item with the oldest one due
    function void check_result(logic [OUT_DATA_W-1:0] tdata, logic [KIND_W-1:0] tuser,
                               logic tlast);
      idx_result_t             want;
      logic [OUT_DATA_W-1:0]   want_data;
      seen++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: none due, got kind %0d data %h last %0b",
                   seen, tuser, tdata, tlast);
        return;
      end
      want      = due_results.pop_front();
      want_data = {{OUT_PAD_W{1'b0}}, want.seg, want.status};
      if (tuser !== want.kind || tdata !== want_data || tlast !== want.is_last) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d: expected kind %0d status %0b id %h last %0b",
                   seen, want.kind, want.status, want.seg, want.is_last);
          $display("result %0d: got kind %0d status %0b id %h pad %h last %0b",
                   seen, tuser, tdata[0], tdata[VAL_W:1],
                   tdata[OUT_DATA_W-1:OUT_USED_W], tlast);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  interval_index_sb sb = new();
  int               items_taken = 0;

  sorted_interval_index #(
    .DEPTH (TAB_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [VAL_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Timestamps: half of them from a narrow window so ranges overlap and starts repeat
  function automatic logic [VAL_W-1:0] pick_stamp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4, 5, 6: return VAL_W'($urandom_range(1, 2000));
      default: return rand64();
    endcase
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic push_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, data);
    items_taken++;
  endtask

  task automatic send_add(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
                          input logic [VAL_W-1:0] id);
    push_item(MODE_ADD, {rand64(), rand64(), id, hi, lo});
  endtask

  task automatic send_query(input logic [VAL_W-1:0] q_lo, input logic [VAL_W-1:0] q_hi);
    push_item(MODE_QUERY, {q_hi, q_lo, rand64(), rand64(), rand64()});
  endtask

  // Idle the sender; a zero-length gap leaves tvalid to the next item
  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Receiver: check result items, stall on a rotating pattern, one long hold
  int       hold_left = 0;
  bit       hold_used = 1'b0;
  int       span_left = 0;
  logic [7:0] rx_pattern = 8'hFF;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser, out_tlast);
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_used && items_taken >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_used = 1'b1;
    end
    if (span_left == 0) begin
      span_left = $urandom_range(64, 256);
      case ($urandom_range(0, 3))
        0:       rx_pattern = 8'hFF;
        1:       rx_pattern = 8'($urandom()) | 8'h01;
        2:       rx_pattern = 8'b1000_0001;
        default: rx_pattern = 8'b0101_0101;
      endcase
    end else begin
      span_left--;
      rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
    end
    out_tready <= (hold_left == 0) && rx_pattern[0];
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sorted_interval_index: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    int burst;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= MODE_ADD;
    in_tdata   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table gives a single no-match
    send_query('0, '0);
    send_add('0, '0, '0);
    send_add('1, '1, '1);
    send_add(64'd100, 64'd200, 64'hA5A5_0000_0000_0001);
    // equal starts keep arrival order
    send_add(64'd100, 64'd150, 64'h5A5A_0000_0000_0002);
    pause(3);
    send_add(64'd100, 64'd300, 64'h0000_FFFF_0000_0003);
    // stored range with start above end
    send_add(64'd500, 64'd50, 64'hFFFF_0000_FFFF_0004);
    send_add(64'd50, 64'd120, 64'h1234_5678_9ABC_DEF0);
    send_query('0, '0);
    send_query('0, 64'd120);
    pause(1);
    send_query(64'd150, '0);
    // query with start above end
    send_query(64'd120, 64'd110);
    send_query(64'd60, 64'd60);
    send_query('1, '1);
    // non-empty table, nothing overlaps
    send_query(64'd1, 64'd1);
    pause(5);

    // random bursts: adds dominate until the table is full, then queries dominate and adds come back full
    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] hi;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        pause($urandom_range(0, 6));
      end
      burst--;
      if ($urandom_range(0, 9) < ((sb.fill < TAB_DEPTH) ? 6 : 3)) begin
        lo = pick_stamp();
        hi = ($urandom_range(0, 3) == 0) ? pick_stamp() : lo + VAL_W'($urandom_range(0, 300));
        send_add(lo, hi, rand64());
      end else begin
        send_query(($urandom_range(0, 2) == 0) ? '0 : pick_stamp(),
                   ($urandom_range(0, 2) == 0) ? '0 : pick_stamp());
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow for a full table walk
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * TAB_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sorted_interval_index: match");
    end else begin
      $display("sorted_interval_index: mismatch");
    end
    $finish;
  end

endmodule
